[rtl/core/fpa_pkg.sv]
package fpa_pkg;

    localparam int DATA_W        = 32;
    localparam int CMD_W         = 4;
    localparam int FPA_FRAC_BITS = 8;

    localparam logic [CMD_W-1:0] CMD_ADD      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB      = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MUL      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIV      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_GT       = 4'd4;
    localparam logic [CMD_W-1:0] CMD_LT       = 4'd5;
    localparam logic [CMD_W-1:0] CMD_GE       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_LE       = 4'd7;
    localparam logic [CMD_W-1:0] CMD_EQ       = 4'd8;
    localparam logic [CMD_W-1:0] CMD_NE       = 4'd9;
    localparam logic [CMD_W-1:0] CMD_MIN      = 4'd10;
    localparam logic [CMD_W-1:0] CMD_MAX      = 4'd11;
    localparam logic [CMD_W-1:0] CMD_INC      = 4'd12;
    localparam logic [CMD_W-1:0] CMD_DEC      = 4'd13;
    localparam logic [CMD_W-1:0] CMD_TO_INT   = 4'd14;
    localparam logic [CMD_W-1:0] CMD_FROM_INT = 4'd15;

endpackage

[rtl/core/fixed_point_alu_q24_8_core.sv]
// Signed fixed-point ALU, 32-bit raw words with FRAC_BITS fractional bits (Q24.8 by
// default). One word is taken per cycle while s_ready is high, and every command,
// divide included, runs through the same pipeline of input register, operation stage,
// divider stages and output register, so results leave in order, one per cycle while
// m_ready is high. The depth is set by the restoring divider: two quotient bits per
// stage over the 32+FRAC_BITS bits of the widened dividend. The multiplier sits in
// the second stage. A stall on m_ready holds the output word; earlier stages keep
// filling bubbles, so s_ready stays high until every stage holds a word.
module fixed_point_alu_q24_8_core #(
    parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fpa_pkg::CMD_W-1:0]         s_command,
    input  logic signed [fpa_pkg::DATA_W-1:0] s_operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] s_operand_b,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [fpa_pkg::DATA_W-1:0] m_result_raw,
    output logic                              m_compare_true,
    output logic                              m_divide_by_zero
);
    import fpa_pkg::*;

    localparam int DW        = DATA_W + FRAC_BITS;
    localparam int STEP_BITS = 2;
    localparam int NSTAGE    = (DW + STEP_BITS - 1) / STEP_BITS;
    localparam int QW        = NSTAGE * STEP_BITS;
    localparam int PW        = 2 * DATA_W;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } in_stage_t;

    typedef struct packed {
        logic              is_mul;
        logic              is_div;
        logic [DATA_W-1:0] simple;
        logic              cmp;
        logic              dz;
        logic              neg;
        logic [PW-1:0]     prod;
        logic [QW-1:0]     dq;
        logic [DATA_W-1:0] dvs;
    } op_stage_t;

    typedef struct packed {
        logic [DATA_W-1:0] res_nd;
        logic              cmp;
        logic              dz;
        logic              is_div;
        logic              neg;
        logic [DATA_W:0]   rem;
        logic [QW-1:0]     dq;
        logic [DATA_W-1:0] dvs;
    } div_stage_t;

    in_stage_t         p1_reg;
    logic              p1_vld_reg;
    op_stage_t         p2_reg;
    op_stage_t         p2_next;
    logic              p2_vld_reg;
    div_stage_t        d_reg  [NSTAGE];
    div_stage_t        d_in   [NSTAGE];
    div_stage_t        d_next [NSTAGE];
    logic [NSTAGE-1:0] d_vld_reg;
    logic [NSTAGE-1:0] en_d;
    logic              en_p1;
    logic              en_p2;
    logic              en_out;

    logic signed [DATA_W-1:0] res_reg;
    logic signed [DATA_W-1:0] res_next;
    logic                     cmp_reg;
    logic                     dz_reg;
    logic                     out_vld_reg;

    // ready chain: a stage advances when empty or when the next one advances
    assign en_out           = ~out_vld_reg | m_ready;
    assign en_d[NSTAGE-1]   = ~d_vld_reg[NSTAGE-1] | en_out;
    assign en_p2            = ~p2_vld_reg | en_d[0];
    assign en_p1            = ~p1_vld_reg | en_p2;
    assign s_ready          = en_p1;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (en_p1) begin
            p1_vld_reg <= s_valid;
        end
        if (en_p1) begin
            p1_reg.cmd <= s_command;
            p1_reg.a   <= s_operand_a;
            p1_reg.b   <= s_operand_b;
        end
    end

    // multiply, simple operations and divider set-up
    always_comb begin
        logic signed [DATA_W-1:0] a_s;
        logic signed [DATA_W-1:0] b_s;
        logic signed [PW-1:0]     prod_s;
        logic [DATA_W-1:0]        amag;
        logic [DW-1:0]            dvd;

        a_s    = p1_reg.a;
        b_s    = p1_reg.b;
        prod_s = a_s * b_s;
        amag   = a_s[DATA_W-1] ? -p1_reg.a : p1_reg.a;
        dvd    = {amag, {FRAC_BITS{1'b0}}};

        p2_next        = '0;
        p2_next.is_mul = (p1_reg.cmd == CMD_MUL);
        p2_next.is_div = (p1_reg.cmd == CMD_DIV);
        p2_next.dz     = (p1_reg.cmd == CMD_DIV) && (p1_reg.b == '0);
        p2_next.neg    = a_s[DATA_W-1] ^ b_s[DATA_W-1];
        p2_next.prod   = prod_s;
        p2_next.dq     = QW'(dvd);
        p2_next.dvs    = b_s[DATA_W-1] ? -p1_reg.b : p1_reg.b;

        unique case (p1_reg.cmd)
            CMD_ADD:      p2_next.simple = p1_reg.a + p1_reg.b;
            CMD_SUB:      p2_next.simple = p1_reg.a - p1_reg.b;
            CMD_GT:       p2_next.cmp    = (a_s > b_s);
            CMD_LT:       p2_next.cmp    = (a_s < b_s);
            CMD_GE:       p2_next.cmp    = (a_s >= b_s);
            CMD_LE:       p2_next.cmp    = (a_s <= b_s);
            CMD_EQ:       p2_next.cmp    = (p1_reg.a == p1_reg.b);
            CMD_NE:       p2_next.cmp    = (p1_reg.a != p1_reg.b);
            CMD_MIN:      p2_next.simple = (a_s < b_s) ? p1_reg.a : p1_reg.b;
            CMD_MAX:      p2_next.simple = (a_s > b_s) ? p1_reg.a : p1_reg.b;
            CMD_INC:      p2_next.simple = p1_reg.a + DATA_W'(1);
            CMD_DEC:      p2_next.simple = p1_reg.a - DATA_W'(1);
            CMD_TO_INT:   p2_next.simple = a_s >>> FRAC_BITS;
            CMD_FROM_INT: p2_next.simple = p1_reg.a << FRAC_BITS;
            default:      p2_next.simple = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else if (en_p2) begin
            p2_vld_reg <= p1_vld_reg;
        end
        if (en_p2) begin
            p2_reg <= p2_next;
        end
    end

    // merge the non-divide result before the divider
    always_comb begin
        d_in[0]        = '0;
        d_in[0].res_nd = p2_reg.is_mul ? p2_reg.prod[FRAC_BITS +: DATA_W] : p2_reg.simple;
        d_in[0].cmp    = p2_reg.cmp;
        d_in[0].dz     = p2_reg.dz;
        d_in[0].is_div = p2_reg.is_div;
        d_in[0].neg    = p2_reg.neg;
        d_in[0].dq     = p2_reg.dq;
        d_in[0].dvs    = p2_reg.dvs;
    end

    // restoring divider, STEP_BITS quotient bits per stage
    for (genvar k = 0; k < NSTAGE; k++) begin : g_div
        if (k > 0) begin : g_link
            assign d_in[k]   = d_reg[k-1];
            assign en_d[k-1] = ~d_vld_reg[k-1] | en_d[k];
        end

        always_comb begin
            div_stage_t      w;
            logic [DATA_W:0] t;
            logic            qb;

            w = d_in[k];
            for (int j = 0; j < STEP_BITS; j++) begin
                t  = {w.rem[DATA_W-1:0], w.dq[QW-1]};
                qb = (t >= {1'b0, w.dvs});
                w.rem = qb ? (t - {1'b0, w.dvs}) : t;
                w.dq  = {w.dq[QW-2:0], qb};
            end
            d_next[k] = w;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_vld_reg[k] <= 1'b0;
            end else if (en_d[k]) begin
                d_vld_reg[k] <= (k == 0) ? p2_vld_reg : d_vld_reg[(k == 0) ? 0 : k-1];
            end
            if (en_d[k]) begin
                d_reg[k] <= d_next[k];
            end
        end
    end

    // final select and sign fix of the quotient
    always_comb begin
        logic [DATA_W-1:0] q;

        q = d_reg[NSTAGE-1].dq[DATA_W-1:0];
        if (d_reg[NSTAGE-1].is_div) begin
            if (d_reg[NSTAGE-1].dz) begin
                res_next = '0;
            end else begin
                res_next = d_reg[NSTAGE-1].neg ? -q : q;
            end
        end else begin
            res_next = d_reg[NSTAGE-1].res_nd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en_out) begin
            out_vld_reg <= d_vld_reg[NSTAGE-1];
        end
        if (en_out) begin
            res_reg <= res_next;
            cmp_reg <= d_reg[NSTAGE-1].cmp;
            dz_reg  <= d_reg[NSTAGE-1].dz;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_result_raw     = res_reg;
    assign m_compare_true   = cmp_reg;
    assign m_divide_by_zero = dz_reg;

endmodule

[rtl/core/fpa_checker.sv]
module fpa_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [fpa_pkg::CMD_W-1:0]         s_command,
    input logic signed [fpa_pkg::DATA_W-1:0] s_operand_a,
    input logic signed [fpa_pkg::DATA_W-1:0] s_operand_b,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [fpa_pkg::DATA_W-1:0] m_result_raw,
    input logic                              m_compare_true,
    input logic                              m_divide_by_zero
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_raw)
            && $stable(m_compare_true) && $stable(m_divide_by_zero))
        else $error("stalled result word changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present after reset");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_compare_true && m_divide_by_zero))
        else $error("compare and divide-by-zero flags both set");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_result_raw == '0)
        else $error("divide by zero with non-zero result");

    a_cmp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_compare_true |-> m_result_raw == '0)
        else $error("comparison with non-zero result");

endmodule

bind fixed_point_alu_q24_8_core fpa_checker u_fpa_checker (.*);

[test/q24_8_result_checker.sv]
module q24_8_result_checker #(
    parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [fpa_pkg::CMD_W-1:0]         s_command,
    input  logic signed [fpa_pkg::DATA_W-1:0] s_operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] s_operand_b,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [fpa_pkg::DATA_W-1:0] m_result_raw,
    input  logic                              m_compare_true,
    input  logic                              m_divide_by_zero,
    output int                                errors,
    output int                                outstanding
);
    import fpa_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] raw;
        logic                     cmp;
        logic                     dz;
    } alu_outcome_t;

    alu_outcome_t awaited_results[$];

    function automatic alu_outcome_t alu_outcome(input logic [CMD_W-1:0] cmd,
                                                 input logic signed [DATA_W-1:0] a,
                                                 input logic signed [DATA_W-1:0] b);
        alu_outcome_t o;
        longint       wide;
        o = '0;
        case (cmd)
            CMD_ADD: o.raw = a + b;
            CMD_SUB: o.raw = a - b;
            CMD_MUL: begin
                wide = longint'(a) * longint'(b);
                wide = wide >>> FRAC_BITS;
                o.raw = wide[DATA_W-1:0];
            end
            CMD_DIV: begin
                if (b == 0) begin
                    o.dz = 1'b1;
                end else begin
                    wide = (longint'(a) <<< FRAC_BITS) / longint'(b);
                    o.raw = wide[DATA_W-1:0];
                end
            end
            CMD_GT:       o.cmp = (a > b);
            CMD_LT:       o.cmp = (a < b);
            CMD_GE:       o.cmp = (a >= b);
            CMD_LE:       o.cmp = (a <= b);
            CMD_EQ:       o.cmp = (a == b);
            CMD_NE:       o.cmp = (a != b);
            CMD_MIN:      o.raw = (a < b) ? a : b;
            CMD_MAX:      o.raw = (a > b) ? a : b;
            CMD_INC:      o.raw = a + 1;
            CMD_DEC:      o.raw = a - 1;
            CMD_TO_INT:   o.raw = a >>> FRAC_BITS;
            CMD_FROM_INT: o.raw = a << FRAC_BITS;
            default:      o = '0;
        endcase
        return o;
    endfunction

    initial begin
        errors = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        alu_outcome_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                awaited_results.push_back(alu_outcome(s_command, s_operand_a, s_operand_b));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result word: result_raw %0d", m_result_raw);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_result_raw !== want.raw) begin
                        $error("result_raw: expected %0d, got %0d", want.raw, m_result_raw);
                        errors++;
                    end
                    if (m_compare_true !== want.cmp) begin
                        $error("compare_true: expected %0b, got %0b", want.cmp,
                               m_compare_true);
                        errors++;
                    end
                    if (m_divide_by_zero !== want.dz) begin
                        $error("divide_by_zero: expected %0b, got %0b", want.dz,
                               m_divide_by_zero);
                        errors++;
                    end
                end
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

[test/tb.sv]
module tb;
    import fpa_pkg::*;

    localparam int                       RANDOM_WORDS = 2000;
    localparam int                       STALL_LIMIT  = 2000;
    localparam int                       DRAIN_CYCLES = 40;
    localparam logic signed [DATA_W-1:0] MAX_RAW      = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] MIN_RAW      = 32'sh80000000;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_command;
    logic signed [DATA_W-1:0] s_operand_a;
    logic signed [DATA_W-1:0] s_operand_b;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_result_raw;
    logic                     m_compare_true;
    logic                     m_divide_by_zero;

    int errors;
    int outstanding;
    int quiet_cycles;
    bit calm;

    fixed_point_alu_q24_8_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_operand_a      (s_operand_a),
        .s_operand_b      (s_operand_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_raw     (m_result_raw),
        .m_compare_true   (m_compare_true),
        .m_divide_by_zero (m_divide_by_zero)
    );

    q24_8_result_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_operand_a      (s_operand_a),
        .s_operand_b      (s_operand_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_raw     (m_result_raw),
        .m_compare_true   (m_compare_true),
        .m_divide_by_zero (m_divide_by_zero),
        .errors           (errors),
        .outstanding      (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && (calm || $urandom_range(99) >= 15);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd,
                             input logic signed [DATA_W-1:0] a,
                             input logic signed [DATA_W-1:0] b);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_operand();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6:          v = $signed($urandom_range(2047)) - 1024;
            7: begin
                case ($urandom_range(5))
                    0:       v = MAX_RAW;
                    1:       v = MIN_RAW;
                    2:       v = -1;
                    3:       v = 1;
                    4:       v = MAX_RAW - $urandom_range(255);
                    default: v = MIN_RAW + $urandom_range(255);
                endcase
            end
            8:       v = ($signed($urandom_range(4095)) - 2048) <<< FPA_FRAC_BITS;
            default: v = '0;
        endcase
        return v;
    endfunction

    initial begin
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_command    = '0;
        s_operand_a  = '0;
        s_operand_b  = '0;
        m_ready      = 1'b0;
        quiet_cycles = 0;
        calm         = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int c = 0; c < (1 << CMD_W); c++)
            send_word(CMD_W'(c), MIN_RAW, MAX_RAW);
        send_word(CMD_DIV, 32'sd5, '0);
        send_word(CMD_DIV, MIN_RAW, -32'sd1);
        send_word(CMD_DIV, -32'sd768, 32'sd512);
        send_word(CMD_MUL, MIN_RAW, MIN_RAW);
        send_word(CMD_MUL, -32'sd1, 32'sd1);
        send_word(CMD_TO_INT, -32'sd1, MAX_RAW);
        send_word(CMD_FROM_INT, MAX_RAW, '0);
        send_word(CMD_INC, MAX_RAW, MIN_RAW);
        send_word(CMD_DEC, MIN_RAW, MAX_RAW);
        send_word(CMD_MIN, 32'sd7, 32'sd7);
        send_word(CMD_ADD, MAX_RAW, MAX_RAW);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= 600 && n < 1000);
            cmd  = CMD_W'($urandom_range((1 << CMD_W) - 1));
            a    = pick_operand();
            case ($urandom_range(9))
                0:       b = a;
                1:       b = (cmd == CMD_DIV) ? '0 : pick_operand();
                default: b = pick_operand();
            endcase
            send_word(cmd, a, b);
        end
        calm = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
